// ===== design/c8lf_pkg.sv =====
// Shared types and constants of the CRC-8 link framer and checker.
// Used by the top level, the CRC unit and the port checker; depends on nothing.
`default_nettype none

package c8lf_pkg;

	// input item selector codes (travel in s_axis_tuser)
	localparam logic [1:0] CMD_BEGIN   = 2'd0;
	localparam logic [1:0] CMD_PAYLOAD = 2'd1;
	localparam logic [1:0] CMD_REPLY   = 2'd2;

	// configuration register indexes
	localparam logic [0:0] REG_START_MARKER = 1'b0;
	localparam logic [0:0] REG_MAX_ATTEMPTS = 1'b1;

	localparam logic [7:0] MARKER_RESET   = 8'hAA;
	localparam logic [3:0] MAX_ATT_RESET  = 4'd10;
	localparam logic [7:0] CRC_POLY       = 8'h07;

	typedef enum logic [1:0] {
		K_FRAME   = 2'd0,
		K_PAYLOAD = 2'd1,
		K_VERDICT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		V_OK            = 3'd0,
		V_STALE_RETRY   = 3'd1,
		V_STALE_EXHAUST = 3'd2,
		V_BAD_START     = 3'd3,
		V_BAD_LEN       = 3'd4,
		V_BAD_CMD       = 3'd5,
		V_BAD_CRC       = 3'd6,
		V_TOO_LONG      = 3'd7
	} verdict_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		verdict_t   verdict;
	} res_t;

	typedef struct packed {
		logic       load;
		logic [7:0] seed;
		logic [7:0] data;
	} crc_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] crc;
	} crc_rsp_t;

endpackage

`default_nettype wire

// ===== design/c8lf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the reply payload bytes; no dependencies.
`default_nettype none

module c8lf_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 24,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/c8lf_crc_unit.sv =====
// Bit-serial CRC-8 unit (poly 0x07, MSB first): one bit per cycle while busy; a new load restarts it.
// Depends on c8lf_pkg for the request/response structs and the polynomial.
`default_nettype none

module c8lf_crc_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire c8lf_pkg::crc_req_t req,
	output c8lf_pkg::crc_rsp_t      rsp
);

	logic [7:0] crc_q;
	logic [2:0] cnt_q;
	logic       busy_q;
	logic       done_q;
	logic [7:0] shifted;

	assign shifted = {crc_q[6:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.load) begin
				crc_q  <= req.seed ^ req.data;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				crc_q <= crc_q[7] ? (shifted ^ c8lf_pkg::CRC_POLY) : shifted;
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.crc  = crc_q;

endmodule

`default_nettype wire

// ===== design/crc8_link_framer_and_checker.sv =====
// Top level of the CRC-8 framed command link: request framer and reply checker.
// Depends on c8lf_pkg, c8lf_crc_unit and c8lf_ram.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+-------------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: cmd; tdata: code,req_len,resp_len,byte
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tuser: kind; tdata: byte,verdict; tlast
//  cfg       | in  | cfg_we (no wait)             | cfg_addr: register, cfg_wdata: value
//
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// An ignored item only passes the decode step; a reply byte inside the frame past the start
// marker enters the CRC, a request payload byte enters it before its results, and a begin
// item runs two CRC passes (length, then code) before its results, or none when refused; a
// judged reply frame emits its verdict and reads each payload byte back from the RAM.
// The bit-serial CRC unit and the payload RAM (an address step, then a data step) set these steps.
// A result waits while the output register is full and m_axis_tready is low; the last result
// of an item waits in the output register while the next item is already taken.
// arst_n clears all control state; no clearing pass is needed.
`default_nettype none

module crc8_link_framer_and_checker #(
	parameter int MAX_PAYLOAD = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // code[7:0], request_len[12:8],
	                                         // response_len[17:13], data_byte[25:18]
	input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // out_byte[7:0], verdict[10:8]
	output logic      [1:0]  m_axis_tuser,  // out_kind[1:0]
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_addr,
	input  wire logic [7:0]  cfg_wdata
);

	localparam int         AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [4:0] MAX_L = 5'(MAX_PAYLOAD);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_CRC    = 6'b000100,
		S_EMIT   = 6'b001000,
		S_RDADDR = 6'b010000,
		S_RDDATA = 6'b100000
	} st_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_SEND = 3'b010,
		PH_RECV = 3'b100
	} ph_t;

	st_t  st_q;
	ph_t  phase_q;

	logic [7:0] marker_q;
	logic [3:0] max_att_q;
	logic [7:0] saved_cmd_q;
	logic [7:0] tx_crc_q;
	logic [4:0] tx_rem_q;
	logic [4:0] reply_len_q;
	logic [4:0] rx_pos_q;
	logic [7:0] rx_crc_q;
	logic [7:0] hdr_q [3];
	logic [3:0] att_q;

	logic [1:0] it_cmd_q;
	logic [7:0] it_code_q;
	logic [4:0] it_rlen_q;
	logic [4:0] it_resp_q;
	logic [7:0] it_byte_q;

	c8lf_pkg::res_t res_q [4];
	logic [2:0]     n_q;
	logic [1:0]     crc_slot_q;
	logic           crc_slot_en_q;
	logic           crc_pass2_q;
	logic           crc_dst_rx_q;
	logic [4:0]     rd_idx_q;

	logic           m_valid_q;
	c8lf_pkg::res_t m_res_q;
	logic           m_last_q;

	c8lf_pkg::crc_req_t crc_req;
	c8lf_pkg::crc_rsp_t crc_rsp;

	logic           slot_free;
	logic           too_long;
	logic [7:0]     lenb;
	logic           begin_ok;
	logic           pay_ok;
	logic           rx_ok;
	logic [5:0]     rx_end;
	logic           rx_in_frame;
	logic           rx_crc_upd;
	logic [4:0]     rx_off;
	logic           ram_we;
	logic           ram_re;
	logic [7:0]     ram_rdata;
	logic           stale;
	logic [3:0]     att_nx;
	logic           exhausted;
	logic           judge_ok;
	c8lf_pkg::res_t judge_res;
	logic [4:0]     rd_nx;
	logic           tx_last;

	// ---------------------------------------------------------------- decode
	always_comb begin
		too_long    = (it_rlen_q > MAX_L) || (it_resp_q > MAX_L);
		lenb        = 8'(it_rlen_q) + 8'd2;
		begin_ok    = (it_cmd_q == c8lf_pkg::CMD_BEGIN) && !too_long;
		pay_ok      = (it_cmd_q == c8lf_pkg::CMD_PAYLOAD) && (phase_q == PH_SEND);
		rx_ok       = (it_cmd_q == c8lf_pkg::CMD_REPLY) && (phase_q == PH_RECV);
		rx_end      = 6'(reply_len_q) + 6'd3;
		rx_in_frame = {1'b0, rx_pos_q} < rx_end;
		rx_crc_upd  = rx_ok && rx_in_frame && (rx_pos_q != 5'd0);
		rx_off      = rx_pos_q - 5'd3;
		ram_we      = (st_q == S_DECODE) && rx_ok && (rx_pos_q >= 5'd3)
		              && (rx_off < reply_len_q);
		ram_re      = (st_q == S_RDADDR);
		rd_nx       = rd_idx_q + 5'd1;
		tx_last     = (tx_rem_q == 5'd1);

		stale     = (hdr_q[0] == marker_q) && (hdr_q[2] != saved_cmd_q);
		att_nx    = att_q + 4'd1;
		exhausted = att_nx >= max_att_q;

		// judging order past the stale check: start, length, command, crc
		judge_ok  = 1'b0;
		judge_res = '{kind: c8lf_pkg::K_VERDICT, data: 8'd0, verdict: c8lf_pkg::V_OK};
		if (hdr_q[0] != marker_q) begin
			judge_res.data    = hdr_q[0];
			judge_res.verdict = c8lf_pkg::V_BAD_START;
		end else if (hdr_q[1] != (8'(reply_len_q) + 8'd2)) begin
			judge_res.verdict = c8lf_pkg::V_BAD_LEN;
		end else if (hdr_q[2] != saved_cmd_q) begin
			judge_res.verdict = c8lf_pkg::V_BAD_CMD;
		end else if (rx_crc_q != it_byte_q) begin
			judge_res.verdict = c8lf_pkg::V_BAD_CRC;
		end else begin
			judge_ok = 1'b1;
		end
	end

	// ------------------------------------------------------------ crc requests
	always_comb begin
		crc_req.load = 1'b0;
		crc_req.seed = rx_crc_q;
		crc_req.data = it_byte_q;
		if (st_q == S_CRC) begin
			crc_req.load = crc_rsp.done && crc_pass2_q;
			crc_req.seed = crc_rsp.crc;
			crc_req.data = it_code_q;
		end else if (st_q == S_DECODE) begin
			crc_req.load = begin_ok || pay_ok || rx_crc_upd;
			if (it_cmd_q == c8lf_pkg::CMD_BEGIN) begin
				crc_req.seed = 8'd0;
				crc_req.data = lenb;
			end else if (it_cmd_q == c8lf_pkg::CMD_PAYLOAD) begin
				crc_req.seed = tx_crc_q;
			end
		end
	end

	c8lf_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crc_req),
		.rsp    (crc_rsp)
	);

	c8lf_ram #(
		.WIDTH  (8),
		.DEPTH  (MAX_PAYLOAD),
		.ADDR_W (AW)
	) u_reply_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rx_off[AW-1:0]),
		.wdata (it_byte_q),
		.re    (ram_re),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign slot_free     = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (st_q == S_IDLE);

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= S_IDLE;
			phase_q       <= PH_IDLE;
			marker_q      <= c8lf_pkg::MARKER_RESET;
			max_att_q     <= c8lf_pkg::MAX_ATT_RESET;
			saved_cmd_q   <= '0;
			tx_crc_q      <= '0;
			tx_rem_q      <= '0;
			reply_len_q   <= '0;
			rx_pos_q      <= '0;
			rx_crc_q      <= '0;
			hdr_q         <= '{default: '0};
			att_q         <= '0;
			it_cmd_q      <= '0;
			it_code_q     <= '0;
			it_rlen_q     <= '0;
			it_resp_q     <= '0;
			it_byte_q     <= '0;
			res_q         <= '{default: '0};
			n_q           <= '0;
			crc_slot_q    <= '0;
			crc_slot_en_q <= 1'b0;
			crc_pass2_q   <= 1'b0;
			crc_dst_rx_q  <= 1'b0;
			rd_idx_q      <= '0;
			m_valid_q     <= 1'b0;
			m_res_q       <= '0;
			m_last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					c8lf_pkg::REG_START_MARKER: marker_q  <= cfg_wdata;
					c8lf_pkg::REG_MAX_ATTEMPTS: max_att_q <= cfg_wdata[3:0];
					default: ;
				endcase
			end

			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (st_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						it_cmd_q  <= s_axis_tuser;
						it_code_q <= s_axis_tdata[7:0];
						it_rlen_q <= s_axis_tdata[12:8];
						it_resp_q <= s_axis_tdata[17:13];
						it_byte_q <= s_axis_tdata[25:18];
						st_q      <= S_DECODE;
					end
				end

				S_DECODE: begin
					st_q <= S_IDLE;
					case (it_cmd_q)
						c8lf_pkg::CMD_BEGIN: begin
							saved_cmd_q <= it_code_q;
							if (too_long) begin
								phase_q  <= PH_IDLE;
								res_q[0] <= '{kind: c8lf_pkg::K_VERDICT, data: 8'd0,
								              verdict: c8lf_pkg::V_TOO_LONG};
								n_q      <= 3'd1;
								st_q     <= S_EMIT;
							end else begin
								reply_len_q   <= it_resp_q;
								res_q[0]      <= '{kind: c8lf_pkg::K_FRAME, data: marker_q,
								                   verdict: c8lf_pkg::V_OK};
								res_q[1]      <= '{kind: c8lf_pkg::K_FRAME, data: lenb,
								                   verdict: c8lf_pkg::V_OK};
								res_q[2]      <= '{kind: c8lf_pkg::K_FRAME, data: it_code_q,
								                   verdict: c8lf_pkg::V_OK};
								res_q[3]      <= '{kind: c8lf_pkg::K_FRAME, data: 8'd0,
								                   verdict: c8lf_pkg::V_OK};
								crc_slot_q    <= 2'd3;
								crc_pass2_q   <= 1'b1;
								crc_dst_rx_q  <= 1'b0;
								st_q          <= S_CRC;
								if (it_rlen_q == 5'd0) begin
									// empty request: CRC byte follows the header
									n_q           <= 3'd4;
									crc_slot_en_q <= 1'b1;
									phase_q       <= PH_RECV;
									rx_pos_q      <= '0;
									rx_crc_q      <= '0;
									att_q         <= '0;
								end else begin
									n_q           <= 3'd3;
									crc_slot_en_q <= 1'b0;
									phase_q       <= PH_SEND;
									tx_rem_q      <= it_rlen_q;
								end
							end
						end

						c8lf_pkg::CMD_PAYLOAD: begin
							if (pay_ok) begin
								res_q[0]      <= '{kind: c8lf_pkg::K_FRAME, data: it_byte_q,
								                   verdict: c8lf_pkg::V_OK};
								res_q[1]      <= '{kind: c8lf_pkg::K_FRAME, data: 8'd0,
								                   verdict: c8lf_pkg::V_OK};
								tx_rem_q      <= tx_rem_q - 5'd1;
								n_q           <= tx_last ? 3'd2 : 3'd1;
								crc_slot_q    <= 2'd1;
								crc_slot_en_q <= tx_last;
								crc_pass2_q   <= 1'b0;
								crc_dst_rx_q  <= 1'b0;
								st_q          <= S_CRC;
								if (tx_last) begin
									phase_q  <= PH_RECV;
									rx_pos_q <= '0;
									rx_crc_q <= '0;
									att_q    <= '0;
								end
							end
						end

						c8lf_pkg::CMD_REPLY: begin
							if (rx_ok) begin
								if (rx_pos_q < 5'd3) begin
									hdr_q[rx_pos_q[1:0]] <= it_byte_q;
								end
								if (rx_in_frame) begin
									rx_pos_q <= rx_pos_q + 5'd1;
									if (rx_crc_upd) begin
										n_q           <= '0;
										crc_slot_en_q <= 1'b0;
										crc_pass2_q   <= 1'b0;
										crc_dst_rx_q  <= 1'b1;
										st_q          <= S_CRC;
									end
								end else begin
									// frame complete: judge it
									rx_pos_q <= '0;
									rx_crc_q <= '0;
									n_q      <= 3'd1;
									st_q     <= S_EMIT;
									if (stale) begin
										att_q    <= att_nx;
										res_q[0] <= '{kind: c8lf_pkg::K_VERDICT, data: 8'd0,
										              verdict: exhausted
										              ? c8lf_pkg::V_STALE_EXHAUST
										              : c8lf_pkg::V_STALE_RETRY};
										if (exhausted) begin
											phase_q <= PH_IDLE;
										end
									end else begin
										phase_q  <= PH_IDLE;
										res_q[0] <= judge_res;
										if (judge_ok && (reply_len_q != 5'd0)) begin
											rd_idx_q <= '0;
											st_q     <= S_RDADDR;
										end
									end
								end
							end
						end

						default: ;
					endcase
				end

				S_CRC: begin
					if (crc_rsp.done) begin
						if (crc_pass2_q) begin
							crc_pass2_q <= 1'b0;
						end else begin
							if (crc_dst_rx_q) begin
								rx_crc_q <= crc_rsp.crc;
							end else begin
								tx_crc_q <= crc_rsp.crc;
							end
							if (crc_slot_en_q) begin
								res_q[crc_slot_q].data <= crc_rsp.crc;
							end
							st_q <= (n_q != 3'd0) ? S_EMIT : S_IDLE;
						end
					end
				end

				S_EMIT: begin
					if (slot_free) begin
						m_valid_q <= 1'b1;
						m_res_q   <= res_q[0];
						m_last_q  <= (n_q == 3'd1);
						res_q[0]  <= res_q[1];
						res_q[1]  <= res_q[2];
						res_q[2]  <= res_q[3];
						n_q       <= n_q - 3'd1;
						if (n_q == 3'd1) begin
							st_q <= S_IDLE;
						end
					end
				end

				S_RDADDR: begin
					st_q <= S_RDDATA;
				end

				S_RDDATA: begin
					// read data holds until the next address is issued
					if (slot_free) begin
						m_valid_q <= 1'b1;
						m_res_q   <= '{kind: c8lf_pkg::K_PAYLOAD, data: ram_rdata,
						              verdict: c8lf_pkg::V_OK};
						m_last_q  <= 1'b0;
						rd_idx_q  <= rd_nx;
						st_q      <= (rd_nx == reply_len_q) ? S_EMIT : S_RDADDR;
					end
				end

				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, m_res_q.verdict, m_res_q.data};
	assign m_axis_tuser  = m_res_q.kind;
	assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

// ===== design/c8lf_checker.sv =====
// Port-level checker for the CRC-8 link framer and checker, bound to the top level.
// Depends on c8lf_pkg for result kind and verdict codes.
`default_nettype none

module c8lf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic [1:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast,
	input wire logic        cfg_we,
	input wire logic [0:0]  cfg_addr,
	input wire logic [7:0]  cfg_wdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
		&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// one item at a time: an accepted item drops ready for the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while previous item in work");

	// byte results carry no verdict
	a_byte_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == c8lf_pkg::K_FRAME
		|| m_axis_tuser == c8lf_pkg::K_PAYLOAD) |-> m_axis_tdata[10:8] == 3'd0)
		else $error("verdict bits set on a byte result");

	// only a bad start verdict carries a byte
	a_verdict_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == c8lf_pkg::K_VERDICT
		&& m_axis_tdata[10:8] != c8lf_pkg::V_BAD_START |-> m_axis_tdata[7:0] == 8'd0)
		else $error("byte set on a verdict other than bad start");

	// a verdict closes its item, a reply payload byte never does
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser != c8lf_pkg::K_VERDICT || m_axis_tlast)
		&& (m_axis_tuser != c8lf_pkg::K_PAYLOAD || !m_axis_tlast))
		else $error("tlast does not match result kind");

endmodule

bind crc8_link_framer_and_checker c8lf_checker u_c8lf_checker (.*);

`default_nettype wire
